// File: src/binned_mean_stdev_histogram_unit_macros.svh
// Assertion helpers shared by the histogram RTL.
`ifndef BINNED_MEAN_STDEV_HISTOGRAM_UNIT_MACROS_SVH
`define BINNED_MEAN_STDEV_HISTOGRAM_UNIT_MACROS_SVH

// Plain property check, clocked on clk, off while reset is low.
`define BMSH_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("bmsh assertion failed");

// Same-cycle implication.
`define BMSH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    `BMSH_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication.
`define BMSH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    `BMSH_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// File: src/bmsh_pkg.sv
package bmsh_pkg;

    localparam int NUM_BINS_DEF = 1024;

    localparam int COUNT_W = 24;
    localparam int SUM_W   = 40;
    localparam int SQ_W    = 56;

    localparam int ALU_W     = 80;
    localparam int DEN_W     = 48;
    localparam int ALU_CNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [ALU_CNT_W-1:0] DIV_X_STEPS    = 7'd32;
    localparam logic [ALU_CNT_W-1:0] DIV_VAR_STEPS  = 7'd80;
    localparam logic [ALU_CNT_W-1:0] DIV_MEAN_STEPS = 7'd41;
    localparam logic [ALU_CNT_W-1:0] SQRT_STEPS     = 7'd16;

    // command kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_ADDED   = 3'd0;
    localparam logic [2:0] STAT_ABOVE   = 3'd1;
    localparam logic [2:0] STAT_NEG_X   = 3'd2;
    localparam logic [2:0] STAT_BIN_OVF = 3'd3;
    localparam logic [2:0] STAT_READ_OK = 3'd4;
    localparam logic [2:0] STAT_EMPTY   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_BIN_WIDTH = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_LIMIT_EN  = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] x_value;
        logic signed [15:0] sample_value;
        logic [9:0]         bin_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [23:0]        entry_count;
        logic signed [15:0] bin_mean;
        logic [15:0]        bin_stdev;
        logic [9:0]         highest_bin_used;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic [SUM_W-1:0]   sum;
        logic [SQ_W-1:0]    sq;
    } entry_t;

    typedef enum logic [1:0] {
        ALU_MUL,
        ALU_DIV,
        ALU_SQRT
    } alu_op_t;

    typedef struct packed {
        logic                 start;
        alu_op_t              op;
        logic [ALU_W-1:0]     opa;
        logic [DEN_W-1:0]     opb;
        logic [ALU_CNT_W-1:0] count;
    } alu_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ALU_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_CHK,
        S_ADD_DIV,
        S_ADD_RD,
        S_ADD_WR,
        S_RD_RD,
        S_RD_LATCH,
        S_MUL_SQ,
        S_MUL_MAG,
        S_MUL_N,
        S_DIV_VAR,
        S_SQRT,
        S_DIV_MEAN,
        S_RESP
    } fsm_t;

endpackage

// File: src/bmsh_ram.sv
module bmsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bmsh_alu.sv
// Shared iterative unit: shift-add multiply, restoring divide,
// bit-pair square root. One step per cycle.
module bmsh_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  bmsh_pkg::alu_req_t req,
    output bmsh_pkg::alu_rsp_t rsp
);
    import bmsh_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    alu_op_t              op_reg, op_next;
    logic [ALU_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ALU_W-1:0]     a_reg, a_next;
    logic [DEN_W-1:0]     b_reg, b_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [ALU_W-1:0]     acc_reg, acc_next;

    logic [DEN_W:0]   div_sh, sq_sh, sq_trial, lhs, rhs;
    logic [DEN_W+1:0] diff;
    logic             take;
    logic [ALU_W-1:0] mul_sum;

    always_comb
    begin
        div_sh   = {rem_reg, a_reg[ALU_W-1]};
        sq_sh    = {rem_reg[DEN_W-2:0], a_reg[ALU_W-1:ALU_W-2]};
        sq_trial = {31'b0, acc_reg[15:0], 2'b01};
        lhs      = (op_reg == ALU_SQRT) ? sq_sh : div_sh;
        rhs      = (op_reg == ALU_SQRT) ? sq_trial : {1'b0, b_reg};
        diff     = {1'b0, lhs} - {1'b0, rhs};
        take     = ~diff[DEN_W+1];
        mul_sum  = acc_reg + (b_reg[0] ? a_reg : '0);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = req.count;
                a_next    = req.opa;
                b_next    = req.opb;
                rem_next  = '0;
                acc_next  = '0;
            end
        end
        else
        begin
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (b_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = mul_sum;
                        a_next   = {a_reg[ALU_W-2:0], 1'b0};
                        b_next   = {1'b0, b_reg[DEN_W-1:1]};
                    end
                end
                ALU_DIV, ALU_SQRT:
                begin
                    rem_next = take ? diff[DEN_W-1:0] : lhs[DEN_W-1:0];
                    acc_next = {acc_reg[ALU_W-2:0], take};
                    a_next   = (op_reg == ALU_SQRT) ? {a_reg[ALU_W-3:0], 2'b00}
                                                    : {a_reg[ALU_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == 7'd1)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// File: src/binned_mean_stdev_histogram_unit.sv
// Binned mean / standard deviation histogram.
// Command channel: a beat (cmd) is taken on a clock edge with start high and
// busy low. Kinds: add sample, read bin, clear all bins.
// Result channel: every command yields exactly one result beat, shown on
// result for the single cycle that result_valid is high. There is no
// back-pressure; the receiver must take it then.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready;
// write only while busy is low. Index 0 bin width, 1 x limit, 2 limit enable.
// Work per command, done by the shared iterative unit where arithmetic is needed:
//   add   unless refused, a 32-step bin-index divide, then a read and a write of the bin
//   read  of a non-empty bin: three shift-add multiplies, an 80-step
//         divide, a 16-step root (skipped on overflow) and a 41-step mean divide
//   clear writes every bin to zero, one bin written per cycle
//   other kinds go straight to the result beat
// One command at a time; busy stays high until the result beat is out.
// Reset: a clearing pass writes every bin to zero, with busy high. Config
// writes are still taken during it.
`include "binned_mean_stdev_histogram_unit_macros.svh"

module binned_mean_stdev_histogram_unit #(
    parameter int NUM_BINS = bmsh_pkg::NUM_BINS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bmsh_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              result_valid,
    output bmsh_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import bmsh_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

    fsm_t state_reg, state_next;

    // config
    logic [30:0]        bin_width_reg;
    logic signed [31:0] x_limit_reg;
    logic               limit_en_reg;

    // command and working state
    cmd_t               cmd_reg, cmd_next;
    logic [AW-1:0]      highest_reg, highest_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;
    logic               clr_item_reg, clr_item_next;
    logic [AW-1:0]      bin_reg, bin_next;
    logic [2:0]         status_reg, status_next;
    logic [23:0]        cnt_out_reg, cnt_out_next;
    logic [15:0]        mean_reg, mean_next;
    logic [15:0]        sd_reg, sd_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [SUM_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [SQ_W-1:0]    sq_reg, sq_next;
    logic [ALU_W-1:0]   p_reg, p_next;
    logic [DEN_W-1:0]   nn_reg, nn_next;

    // memory
    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [$bits(entry_t)-1:0] ram_wdata, ram_rdata;
    entry_t              rd_entry, upd_entry;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic               limit_hit, bin_ovf, rd_oob, arith_state;
    logic [DEN_W-1:0]   width_div;
    logic signed [31:0] v_sq;
    logic [40:0]        mean_num;
    logic [40:0]        mq;

    bmsh_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    bmsh_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (alu_req),
        .rsp  (alu_rsp)
    );

    assign rd_entry  = ram_rdata;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        limit_hit = limit_en_reg && (cmd_reg.x_value >= x_limit_reg);
        bin_ovf   = alu_rsp.result[31:0] >= 32'(NUM_BINS);
        rd_oob    = {22'b0, cmd_reg.bin_index} >= 32'(NUM_BINS);
        width_div = (bin_width_reg == '0) ? DEN_W'(1) : {17'b0, bin_width_reg};
        v_sq      = cmd_reg.sample_value * cmd_reg.sample_value;
        mean_num  = {mag_reg, 1'b0} + {17'b0, n_reg};
        mq        = alu_rsp.result[40:0];
        arith_state = (state_reg == S_ADD_DIV) || (state_reg == S_MUL_SQ) ||
                      (state_reg == S_MUL_MAG) || (state_reg == S_MUL_N) ||
                      (state_reg == S_DIV_VAR) || (state_reg == S_SQRT) ||
                      (state_reg == S_DIV_MEAN);
        // a full bin keeps its totals
        upd_entry = rd_entry;
        if (rd_entry.cnt != COUNT_MAX)
        begin
            upd_entry.cnt = rd_entry.cnt + 1'b1;
            upd_entry.sum = rd_entry.sum + {{24{cmd_reg.sample_value[15]}},
                                            cmd_reg.sample_value};
            upd_entry.sq  = rd_entry.sq + {24'b0, v_sq};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == LAST_BIN)
                begin
                    state_next = clr_item_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.kind)
                        KIND_ADD:   state_next = S_ADD_CHK;
                        KIND_READ:  state_next = S_RD_RD;
                        KIND_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_ADD_CHK:
                state_next = (limit_hit || cmd_reg.x_value[31]) ? S_RESP : S_ADD_DIV;
            S_ADD_DIV:
            begin
                if (alu_rsp.done)
                begin
                    state_next = bin_ovf ? S_RESP : S_ADD_RD;
                end
            end
            S_ADD_RD:   state_next = S_ADD_WR;
            S_ADD_WR:   state_next = S_RESP;
            S_RD_RD:    state_next = rd_oob ? S_RESP : S_RD_LATCH;
            S_RD_LATCH: state_next = (rd_entry.cnt == '0) ? S_RESP : S_MUL_SQ;
            S_MUL_SQ:   if (alu_rsp.done) state_next = S_MUL_MAG;
            S_MUL_MAG:  if (alu_rsp.done) state_next = S_MUL_N;
            S_MUL_N:    if (alu_rsp.done) state_next = S_DIV_VAR;
            S_DIV_VAR:
            begin
                if (alu_rsp.done)
                begin
                    state_next = (alu_rsp.result[ALU_W-1:32] != '0) ? S_DIV_MEAN : S_SQRT;
                end
            end
            S_SQRT:     if (alu_rsp.done) state_next = S_DIV_MEAN;
            S_DIV_MEAN: if (alu_rsp.done) state_next = S_RESP;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs: handshake, memory port, unit request, result fields
    always_comb
    begin
        busy         = (state_reg != S_IDLE);
        result_valid = (state_reg == S_RESP);

        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_ADD_WR);
        ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : bin_reg;
        ram_wdata = (state_reg == S_CLEAR) ? '0 : upd_entry;
        ram_re    = (state_reg == S_ADD_RD) || (state_reg == S_RD_RD);
        ram_raddr = (state_reg == S_ADD_RD) ? bin_reg : AW'(cmd_reg.bin_index);

        alu_req.start = arith_state && !alu_rsp.busy && !alu_rsp.done;
        alu_req.op    = ALU_MUL;
        alu_req.opa   = '0;
        alu_req.opb   = '0;
        alu_req.count = '0;
        unique case (state_reg)
            S_ADD_DIV:
            begin
                alu_req.op    = ALU_DIV;
                alu_req.opa   = {cmd_reg.x_value, 48'b0};
                alu_req.opb   = width_div;
                alu_req.count = DIV_X_STEPS;
            end
            S_MUL_SQ:
            begin
                alu_req.opa = {24'b0, sq_reg};
                alu_req.opb = {24'b0, n_reg};
            end
            S_MUL_MAG:
            begin
                alu_req.opa = {40'b0, mag_reg};
                alu_req.opb = {8'b0, mag_reg};
            end
            S_MUL_N:
            begin
                alu_req.opa = {56'b0, n_reg};
                alu_req.opb = {24'b0, n_reg};
            end
            S_DIV_VAR:
            begin
                alu_req.op    = ALU_DIV;
                alu_req.opa   = p_reg;
                alu_req.opb   = nn_reg;
                alu_req.count = DIV_VAR_STEPS;
            end
            S_SQRT:
            begin
                alu_req.op    = ALU_SQRT;
                alu_req.opa   = {p_reg[31:0], 48'b0};
                alu_req.count = SQRT_STEPS;
            end
            S_DIV_MEAN:
            begin
                alu_req.op    = ALU_DIV;
                alu_req.opa   = {mean_num, 39'b0};
                alu_req.opb   = {23'b0, n_reg, 1'b0};
                alu_req.count = DIV_MEAN_STEPS;
            end
            default:
            begin
            end
        endcase

        result.status           = status_reg;
        result.entry_count      = cnt_out_reg;
        result.bin_mean         = mean_reg;
        result.bin_stdev        = sd_reg;
        result.highest_bin_used = 10'(highest_reg);
    end

    // datapath
    always_comb
    begin
        cmd_next      = cmd_reg;
        highest_next  = highest_reg;
        clr_addr_next = clr_addr_reg;
        clr_item_next = clr_item_reg;
        bin_next      = bin_reg;
        status_next   = status_reg;
        cnt_out_next  = cnt_out_reg;
        mean_next     = mean_reg;
        sd_next       = sd_reg;
        n_next        = n_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        sq_next       = sq_reg;
        p_next        = p_reg;
        nn_next       = nn_reg;
        unique case (state_reg)
            S_CLEAR:
                clr_addr_next = (clr_addr_reg == LAST_BIN) ? '0 : clr_addr_reg + 1'b1;
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next      = cmd;
                    status_next   = STAT_ADDED;
                    cnt_out_next  = '0;
                    mean_next     = '0;
                    sd_next       = '0;
                    clr_item_next = (cmd.kind == KIND_CLEAR);
                    if (cmd.kind == KIND_CLEAR)
                    begin
                        highest_next = '0;
                    end
                    if ((cmd.kind != KIND_ADD) && (cmd.kind != KIND_READ) &&
                        (cmd.kind != KIND_CLEAR))
                    begin
                        status_next = STAT_EMPTY;
                    end
                end
            end
            S_ADD_CHK:
            begin
                // limit check wins over negative x
                priority if (limit_hit)
                    status_next = STAT_ABOVE;
                else if (cmd_reg.x_value[31])
                    status_next = STAT_NEG_X;
                else
                    status_next = status_reg;
            end
            S_ADD_DIV:
            begin
                if (alu_rsp.done)
                begin
                    bin_next = alu_rsp.result[AW-1:0];
                    if (bin_ovf)
                    begin
                        status_next = STAT_BIN_OVF;
                    end
                end
            end
            S_ADD_WR:
            begin
                if (bin_reg > highest_reg)
                begin
                    highest_next = bin_reg;
                end
            end
            S_RD_RD:
            begin
                if (rd_oob)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            S_RD_LATCH:
            begin
                n_next   = rd_entry.cnt;
                neg_next = rd_entry.sum[SUM_W-1];
                mag_next = rd_entry.sum[SUM_W-1] ? (SUM_W'(0) - rd_entry.sum) : rd_entry.sum;
                sq_next  = rd_entry.sq;
                if (rd_entry.cnt == '0)
                begin
                    status_next = STAT_EMPTY;
                end
            end
            S_MUL_SQ:
                if (alu_rsp.done) p_next = alu_rsp.result;
            S_MUL_MAG:
                if (alu_rsp.done) p_next = p_reg - alu_rsp.result;
            S_MUL_N:
                if (alu_rsp.done) nn_next = alu_rsp.result[DEN_W-1:0];
            S_DIV_VAR:
            begin
                if (alu_rsp.done)
                begin
                    p_next = alu_rsp.result;
                    if (alu_rsp.result[ALU_W-1:32] != '0)
                    begin
                        sd_next = 16'hFFFF;
                    end
                end
            end
            S_SQRT:
                if (alu_rsp.done) sd_next = alu_rsp.result[15:0];
            S_DIV_MEAN:
            begin
                if (alu_rsp.done)
                begin
                    status_next  = STAT_READ_OK;
                    cnt_out_next = n_reg;
                    if (neg_reg)
                    begin
                        mean_next = (mq >= 41'd32768) ? 16'h8000 : 16'(16'd0 - mq[15:0]);
                    end
                    else
                    begin
                        mean_next = (mq > 41'd32767) ? 16'h7FFF : mq[15:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            highest_reg   <= '0;
            clr_addr_reg  <= '0;
            clr_item_reg  <= 1'b0;
            bin_width_reg <= 31'd65536;
            x_limit_reg   <= 32'sh7FFF_FFFF;
            limit_en_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            highest_reg  <= highest_next;
            clr_addr_reg <= clr_addr_next;
            clr_item_reg <= clr_item_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_BIN_WIDTH: bin_width_reg <= cfg_data[30:0];
                    CFG_X_LIMIT:   x_limit_reg   <= cfg_data;
                    CFG_LIMIT_EN:  limit_en_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        bin_reg     <= bin_next;
        status_reg  <= status_next;
        cnt_out_reg <= cnt_out_next;
        mean_reg    <= mean_next;
        sd_reg      <= sd_next;
        n_reg       <= n_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        sq_reg      <= sq_next;
        p_reg       <= p_next;
        nn_reg      <= nn_next;
    end

    `BMSH_ASSERT_IMP(a_strobe_busy, clk, rst_n, result_valid, busy)
    `BMSH_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `BMSH_ASSERT_NXT(a_one_beat, clk, rst_n, result_valid, !result_valid)
    `BMSH_ASSERT_IMP(a_alu_idle_start, clk, rst_n, alu_req.start, !alu_rsp.busy)
    `BMSH_ASSERT_IMP(a_no_write_on_read, clk, rst_n, ram_we, !ram_re)

endmodule
